/* rtl/alarm_table_scheduler_macros.svh */
// Assertion macros shared by the alarm table scheduler RTL.
`ifndef ALARM_TABLE_SCHEDULER_MACROS_SVH
`define ALARM_TABLE_SCHEDULER_MACROS_SVH

// Checks a consequence in the same cycle as its cause, clocked on i_clk.
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its cause, clocked on i_clk.
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ats_pkg.sv */
// Shared types, constants and the microcode program of the alarm table scheduler.
package ats_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam logic [31:0] DEFAULT_PERIOD = 32'd86400;

    // Result status codes.
    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_NOMATCH = 3'd4;
    localparam logic [2:0] ST_FIRED   = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    // Program counter and step addresses.
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] STEP_IDLE          = 3'd0;
    localparam logic [PC_W-1:0] STEP_COMMIT_SCAN   = 3'd1;
    localparam logic [PC_W-1:0] STEP_COMMIT_FINISH = 3'd2;
    localparam logic [PC_W-1:0] STEP_CHECK_SCAN    = 3'd3;
    localparam logic [PC_W-1:0] STEP_CHECK_DONE    = 3'd4;

    // Jump conditions.
    localparam logic [1:0] COND_NEXT     = 2'd0;
    localparam logic [1:0] COND_GOTO     = 2'd1;
    localparam logic [1:0] COND_MORE     = 2'd2;
    localparam logic [1:0] COND_IS_CHECK = 2'd3;

    typedef struct packed {
        logic        op;
        logic [63:0] alarm_key;
        logic [31:0] alarm_time;
        logic        repeat_daily;
        logic [31:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] fired_key;
        logic        last;
    } t_out;

    // Datapath actions, one bit each.
    typedef struct packed {
        logic accept;
        logic commit_scan;
        logic commit_finish;
        logic check_scan;
        logic emit_done;
    } t_strobe;

    typedef struct packed {
        t_strobe         act;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } t_ucode;

    // Datapath flags seen by the sequencer.
    typedef struct packed {
        logic in_op_check;
        logic last_slot;
        logic fire;
        logic out_free;
    } t_dp_stat;

    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        w = '0;
        case (pc)
            STEP_IDLE: begin
                w.act.accept = 1'b1;
                w.cond       = COND_IS_CHECK;
                w.target     = STEP_CHECK_SCAN;
            end
            STEP_COMMIT_SCAN: begin
                w.act.commit_scan = 1'b1;
                w.cond            = COND_MORE;
                w.target          = STEP_COMMIT_SCAN;
            end
            STEP_COMMIT_FINISH: begin
                w.act.commit_finish = 1'b1;
                w.cond              = COND_GOTO;
                w.target            = STEP_IDLE;
            end
            STEP_CHECK_SCAN: begin
                w.act.check_scan = 1'b1;
                w.cond           = COND_MORE;
                w.target         = STEP_CHECK_SCAN;
            end
            STEP_CHECK_DONE: begin
                w.act.emit_done = 1'b1;
                w.cond          = COND_GOTO;
                w.target        = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_GOTO;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/ats_chan_if.sv */
// Valid/ready channel interface carrying one payload per transaction.
interface ats_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/alarm_table_scheduler.sv */
// Top level of the alarm table scheduler: channels, period register and sequencer.
//
// Usage. Items arrive on i_cmd, a valid/ready channel; a transaction is taken
// when valid and ready are both high at a rising edge of i_clk. op = 0 commits
// an alarm (add, update or remove, one result); op = 1 checks the table against
// now_seconds and gives one fired result per due alarm, in slot order, then a
// done result with last set. Results leave on o_res under the same handshake.
// i_cfg_we with i_cfg_wdata writes the repeat period; write it only when idle.
// Timing: a microcoded sequencer walks the table one slot per cycle, unless a
// fired alarm waits for room in the result register. An item is scanned in full
// before i_cmd is ready for the next one, as the scan reads a single slot at a time.
// The first result is registered at the finish step after the scan for a
// commit, or when its slot is visited for a fired alarm.
// When the receiver stalls, the result register holds and the sequencer waits
// on the step that wants to emit; nothing is lost or repeated.
// After reset every slot is empty, the period is 86400 seconds, and i_cmd is
// ready.
module alarm_table_scheduler #(
    parameter int SLOT_COUNT = ats_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ats_chan_if.sink          i_cmd,
    ats_chan_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata
);
    logic [31:0]       r_repeat_period;
    ats_pkg::t_strobe  act;
    ats_pkg::t_dp_stat stat;
    logic              in_ready;
    logic              res_valid;
    ats_pkg::t_out     res_payload;

    // The repeat period register; the user must write it only between items, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_period <= ats_pkg::DEFAULT_PERIOD;
        end else if (i_cfg_we) begin
            r_repeat_period <= i_cfg_wdata;
        end
    end

    // The sequencer steps through the program: accept, scan, finish or done.
    ats_ucode_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_act      (act)
    );

    // The datapath holds the table and the result register.
    ats_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_act           (act),
        .i_cmd_payload   (i_cmd.payload),
        .i_repeat_period (r_repeat_period),
        .i_res_ready     (o_res.ready),
        .o_stat          (stat),
        .o_res_valid     (res_valid),
        .o_res_payload   (res_payload)
    );

    assign i_cmd.ready   = in_ready;
    assign o_res.valid   = res_valid;
    assign o_res.payload = res_payload;
endmodule

/* rtl/ats_ucode_seq.sv */
// Microcode sequencer: program counter, control ROM, stall and jump logic.
module ats_ucode_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ats_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output ats_pkg::t_strobe   o_act
);
    logic [ats_pkg::PC_W-1:0] r_pc;
    logic [ats_pkg::PC_W-1:0] n_pc;
    logic [ats_pkg::PC_W-1:0] pc_inc;
    ats_pkg::t_ucode          cw;
    logic                     needs_out;
    logic                     hold;

    assign cw     = ats_pkg::ucode_rom(r_pc);
    assign pc_inc = r_pc + ats_pkg::PC_W'(1);

    // A step stalls while it waits for a transaction or for room in the result register.
    assign needs_out = cw.act.commit_finish || cw.act.emit_done
                       || (cw.act.check_scan && i_stat.fire);
    assign hold      = (cw.act.accept && !i_in_valid) || (needs_out && !i_stat.out_free);

    assign o_in_ready = cw.act.accept;
    assign o_act      = hold ? '0 : cw.act;

    always_comb begin
        n_pc = r_pc;
        if (!hold) begin
            case (cw.cond)
                ats_pkg::COND_NEXT:     n_pc = pc_inc;
                ats_pkg::COND_GOTO:     n_pc = cw.target;
                ats_pkg::COND_MORE:     n_pc = i_stat.last_slot ? pc_inc : cw.target;
                ats_pkg::COND_IS_CHECK: n_pc = i_stat.in_op_check ? cw.target : pc_inc;
                default:                n_pc = ats_pkg::STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ats_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end
endmodule

/* rtl/ats_datapath.sv */
// Alarm table, slot scan registers and the result register.
module ats_datapath #(
    parameter int SLOT_COUNT = ats_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ats_pkg::t_strobe  i_act,
    input  ats_pkg::t_in      i_cmd_payload,
    input  logic [31:0]       i_repeat_period,
    input  logic              i_res_ready,
    output ats_pkg::t_dp_stat o_stat,
    output logic              o_res_valid,
    output ats_pkg::t_out     o_res_payload
);
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Stored keys are always nonzero, so a valid bit stands for an occupied slot.
    logic [63:0]      r_key [SLOT_COUNT];
    logic [31:0]      r_due [SLOT_COUNT];
    logic             r_rep [SLOT_COUNT];
    logic             r_vld [SLOT_COUNT];

    logic [IDX_W-1:0] r_idx;
    logic [63:0]      r_key_in;
    logic [31:0]      r_time_in;
    logic             r_rep_in;
    logic [31:0]      r_now;
    logic             r_match_found;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_empty_found;
    logic [IDX_W-1:0] r_empty_idx;
    logic             r_hit;

    logic             r_out_valid;
    ats_pkg::t_out    r_out;

    logic             cur_vld;
    logic [63:0]      cur_key;
    logic [31:0]      cur_due;
    logic             cur_rep;
    logic             cur_match;
    logic             fire;
    logic             last_slot;
    logic             is_remove;
    logic             key_zero;
    logic [IDX_W-1:0] n_idx;
    logic [2:0]       commit_status;
    logic             emit_fire;
    logic             out_load;
    ats_pkg::t_out    n_out;

    assign cur_vld   = r_vld[r_idx];
    assign cur_key   = r_key[r_idx];
    assign cur_due   = r_due[r_idx];
    assign cur_rep   = r_rep[r_idx];
    assign cur_match = cur_vld && (cur_key == r_key_in);
    assign fire      = cur_vld && (cur_due < r_now);
    assign last_slot = (r_idx == IDX_W'(SLOT_COUNT - 1));
    assign is_remove = (r_time_in == 32'd0);
    assign key_zero  = (r_key_in == 64'd0);
    assign n_idx     = last_slot ? '0 : r_idx + IDX_W'(1);

    always_comb begin
        if (is_remove) begin
            commit_status = r_hit ? ats_pkg::ST_REMOVED : ats_pkg::ST_NOMATCH;
        end else if (key_zero) begin
            commit_status = ats_pkg::ST_FULL;
        end else if (r_match_found) begin
            commit_status = ats_pkg::ST_UPDATED;
        end else if (r_empty_found) begin
            commit_status = ats_pkg::ST_CREATED;
        end else begin
            commit_status = ats_pkg::ST_FULL;
        end
    end

    assign emit_fire = i_act.check_scan && fire;
    assign out_load  = i_act.commit_finish || i_act.emit_done || emit_fire;

    always_comb begin
        n_out = '0;
        if (i_act.commit_finish) begin
            n_out.status = commit_status;
            n_out.last   = 1'b1;
        end else if (i_act.emit_done) begin
            n_out.status = ats_pkg::ST_DONE;
            n_out.last   = 1'b1;
        end else begin
            n_out.status    = ats_pkg::ST_FIRED;
            n_out.fired_key = cur_key;
        end
    end

    assign o_stat.in_op_check = i_cmd_payload.op;
    assign o_stat.last_slot   = last_slot;
    assign o_stat.fire        = fire;
    assign o_stat.out_free    = !r_out_valid || i_res_ready;
    assign o_res_valid        = r_out_valid;
    assign o_res_payload      = r_out;

    // Control state and slot occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_idx         <= '0;
            r_match_found <= 1'b0;
            r_empty_found <= 1'b0;
            r_hit         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_act.accept) begin
                r_idx         <= '0;
                r_match_found <= 1'b0;
                r_empty_found <= 1'b0;
                r_hit         <= 1'b0;
            end
            if (i_act.commit_scan) begin
                if (cur_match) begin
                    r_match_found <= 1'b1;
                    if (is_remove) begin
                        r_vld[r_idx] <= 1'b0;
                        r_hit        <= 1'b1;
                    end
                end
                if (!cur_vld) begin
                    r_empty_found <= 1'b1;
                end
                r_idx <= n_idx;
            end
            if (i_act.commit_finish && !is_remove && !key_zero && !r_match_found
                && r_empty_found) begin
                r_vld[r_empty_idx] <= 1'b1;
            end
            if (i_act.check_scan) begin
                if (fire && !cur_rep) begin
                    r_vld[r_idx] <= 1'b0;
                end
                r_idx <= n_idx;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Slot contents, the latched item and the result payload.
    always_ff @(posedge i_clk) begin
        if (i_act.accept) begin
            r_key_in  <= i_cmd_payload.alarm_key;
            r_time_in <= i_cmd_payload.alarm_time;
            r_rep_in  <= i_cmd_payload.repeat_daily;
            r_now     <= i_cmd_payload.now_seconds;
        end
        if (i_act.commit_scan) begin
            if (cur_match && !r_match_found) begin
                r_match_idx <= r_idx;
            end
            if (!cur_vld && !r_empty_found) begin
                r_empty_idx <= r_idx;
            end
        end
        if (i_act.commit_finish && !is_remove && !key_zero) begin
            if (r_match_found) begin
                r_due[r_match_idx] <= r_time_in;
                r_rep[r_match_idx] <= r_rep_in;
            end else if (r_empty_found) begin
                r_key[r_empty_idx] <= r_key_in;
                r_due[r_empty_idx] <= r_time_in;
                r_rep[r_empty_idx] <= r_rep_in;
            end
        end
        if (emit_fire && cur_rep) begin
            r_due[r_idx] <= cur_due + i_repeat_period;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

`include "alarm_table_scheduler_macros.svh"

    `ATS_ASSERT_NOW(a_one_action, 1'b1, $onehot0(i_act), "more than one datapath action")
    `ATS_ASSERT_NOW(a_load_free, out_load, (!r_out_valid || i_res_ready), "result overwritten")
    `ATS_ASSERT_NEXT(a_scan_start, i_act.accept, (r_idx == '0), "scan not restarted")
    `ATS_ASSERT_NEXT(a_fired_key, emit_fire, (r_out.fired_key != 64'd0), "fired empty slot")
    `ATS_ASSERT_NEXT(a_created, (i_act.commit_finish && commit_status == ats_pkg::ST_CREATED), r_vld[$past(r_empty_idx)], "created slot not occupied")
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the alarm table scheduler: directed and random traffic.
module tb;

    localparam int   SLOTS           = ats_pkg::SLOT_COUNT_DEF;
    localparam logic OP_COMMIT       = 1'b0;
    localparam logic OP_CHECK        = 1'b1;
    // An item is scanned in full before the next can be taken; the settle time adds margin on top.
    localparam int   SETTLE_CYCLES   = SLOTS + 6;
    localparam int   PHASES          = 4;
    localparam int   ITEMS_PER_PHASE = 60;
    localparam int   KEY_POOL_SIZE   = 11;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;

    // Percentages that steer the idling of the sender and the stalling of the receiver.
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned error_count = 0;

    // Our own copy of the alarm table and of the period register.
    logic [63:0] slot_key     [SLOTS];
    logic [31:0] slot_due     [SLOTS];
    logic        slot_repeats [SLOTS];
    logic [31:0] rearm_period = ats_pkg::DEFAULT_PERIOD;

    // Results that the block still owes us, oldest first.
    ats_pkg::t_out pending_results [$];

    // Random traffic draws its keys from a small pool, so that updates, removals and a
    // full table all turn up, and its times from a wall clock that only moves forward.
    logic [63:0] key_pool [KEY_POOL_SIZE];
    logic [31:0] wall_clock;

    ats_chan_if #(.t_payload(ats_pkg::t_in))  cmd_ch ();
    ats_chan_if #(.t_payload(ats_pkg::t_out)) res_ch ();

    alarm_table_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Every input of the block holds a known value from time zero.
    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]     = '0;
            slot_due[i]     = '0;
            slot_repeats[i] = 1'b0;
        end
    end

    // The receiver changes its mind at each falling edge, so a stall can land on any cycle.
    always @(negedge clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void clear_slot(input int idx);
        slot_key[idx]     = '0;
        slot_due[idx]     = '0;
        slot_repeats[idx] = 1'b0;
    endfunction

    // Works out the results of one accepted transaction and updates our copy of the table.
    function automatic void predict_alarm_results(input ats_pkg::t_in item);
        ats_pkg::t_out res;
        logic          found;
        res   = '0;
        found = 1'b0;
        if (item.op == OP_CHECK) begin
            // Slots are visited in order; a due time equal to now is not yet due.
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_key[i] != '0 && slot_due[i] < item.now_seconds) begin
                    res.status    = ats_pkg::ST_FIRED;
                    res.fired_key = slot_key[i];
                    res.last      = 1'b0;
                    pending_results.push_back(res);
                    if (slot_repeats[i]) begin
                        slot_due[i] = slot_due[i] + rearm_period;
                    end else begin
                        clear_slot(i);
                    end
                end
            end
            res.status    = ats_pkg::ST_DONE;
            res.fired_key = '0;
            res.last      = 1'b1;
            pending_results.push_back(res);
            return;
        end
        res.last = 1'b1;
        if (item.alarm_time == '0) begin
            // A removal clears every slot that carries the key; key zero never matches.
            res.status = ats_pkg::ST_NOMATCH;
            if (item.alarm_key != '0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_key[i] == item.alarm_key) begin
                        clear_slot(i);
                        res.status = ats_pkg::ST_REMOVED;
                    end
                end
            end
        end else if (item.alarm_key == '0) begin
            res.status = ats_pkg::ST_FULL;
        end else begin
            // Update the first matching slot, else fill the lowest empty one.
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && slot_key[i] == item.alarm_key) begin
                    slot_due[i]     = item.alarm_time;
                    slot_repeats[i] = item.repeat_daily;
                    res.status      = ats_pkg::ST_UPDATED;
                    found           = 1'b1;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && slot_key[i] == '0) begin
                    slot_key[i]     = item.alarm_key;
                    slot_due[i]     = item.alarm_time;
                    slot_repeats[i] = item.repeat_daily;
                    res.status      = ats_pkg::ST_CREATED;
                    found           = 1'b1;
                end
            end
            if (!found) begin
                res.status = ats_pkg::ST_FULL;
            end
        end
        pending_results.push_back(res);
    endfunction

    function automatic ats_pkg::t_in make_item(input logic op, input logic [63:0] key,
                                               input logic [31:0] due, input logic rep,
                                               input logic [31:0] now);
        ats_pkg::t_in item;
        item.op           = op;
        item.alarm_key    = key;
        item.alarm_time   = due;
        item.repeat_daily = rep;
        item.now_seconds  = now;
        return item;
    endfunction

    // One random transaction. Most are well-formed commits and checks around the wall
    // clock; a few are pure noise or carry key zero.
    function automatic ats_pkg::t_in random_item();
        ats_pkg::t_in item;
        int unsigned  pick;
        pick              = $urandom_range(99);
        item.op           = OP_COMMIT;
        item.alarm_key    = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        item.alarm_time   = wall_clock + $urandom_range(400) - 32'd100;
        item.repeat_daily = 1'($urandom_range(1));
        item.now_seconds  = $urandom;
        if (pick < 8) begin
            item.op         = 1'($urandom_range(1));
            item.alarm_key  = {$urandom, $urandom};
            item.alarm_time = $urandom;
        end else if (pick < 12) begin
            item.alarm_key = '0;
            if ($urandom_range(1) == 0) begin
                item.alarm_time = '0;
            end
        end else if (pick < 62) begin
            if (pick >= 50) begin
                item.alarm_time = '0;
            end else if (item.alarm_time == '0) begin
                item.alarm_time = 32'd1;
            end
        end else begin
            wall_clock       = wall_clock + $urandom_range(160);
            item.op          = OP_CHECK;
            item.now_seconds = wall_clock;
        end
        return item;
    endfunction

    // Presents one item and waits for its transaction. The valid line is only ever
    // driven once per falling edge, so back-to-back items keep it high throughout.
    task automatic send_item(input ats_pkg::t_in item);
        int unsigned gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 24) : 0;
        repeat (gap) begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= item;
        do @(posedge clk); while (!cmd_ch.ready);
        predict_alarm_results(item);
    endtask

    // Stops sending and waits until every owed result has arrived and the scan has finished.
    task automatic wait_until_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The period may only change while the block is idle.
    task automatic write_repeat_period(input logic [31:0] value);
        wait_until_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        rearm_period  = value;
    endtask

    // Commit rules on an empty and then a full table, with key zero and the widest key.
    task automatic test_commit_rules();
        send_item(make_item(OP_COMMIT, 64'd1, 32'd0, 1'b0, 32'd0));
        send_item(make_item(OP_COMMIT, 64'd0, 32'd5, 1'b1, 32'd0));
        send_item(make_item(OP_COMMIT, 64'd0, 32'd0, 1'b0, 32'd0));
        send_item(make_item(OP_COMMIT, '1, '1, 1'b1, '1));
        send_item(make_item(OP_COMMIT, 64'd1, 32'd100, 1'b0, 32'd0));
        send_item(make_item(OP_COMMIT, 64'd1, 32'd50, 1'b1, 32'd0));
        for (int k = 2; k <= 7; k++) begin
            send_item(make_item(OP_COMMIT, {32'hA5A5_0000 | 32'(k), 32'h5A5A_0000 | 32'(k)},
                                32'(10 * k), (k % 2) == 0, 32'd0));
        end
        // Every slot is taken now, so a new key cannot be placed.
        send_item(make_item(OP_COMMIT, 64'd8, 32'd70, 1'b0, 32'd0));
        send_item(make_item(OP_COMMIT, '1, 32'd0, 1'b0, 32'd0));
        send_item(make_item(OP_COMMIT, '1, 32'd0, 1'b0, 32'd0));
        wait_until_drained();
    endtask

    // Checks with nothing due, with almost everything due, and at the strict boundary.
    task automatic test_check_rules();
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, 32'd0));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, '1));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, '1));
        send_item(make_item(OP_COMMIT, 64'd9, 32'd500, 1'b0, 32'd0));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, 32'd500));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, 32'd501));
        wait_until_drained();
    endtask

    // The smallest and the largest period; the largest wraps a due time round to just
    // below itself, so the alarm is due again at once.
    task automatic test_repeat_period_extremes();
        write_repeat_period(32'd1);
        send_item(make_item(OP_COMMIT, 64'hC0DE_0000_0000_00A1, 32'd1000, 1'b1, 32'd0));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, 32'd1001));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, 32'd1002));
        write_repeat_period('1);
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, 32'd1003));
        send_item(make_item(OP_CHECK, 64'd0, 32'd0, 1'b0, 32'd1003));
        wait_until_drained();
    endtask

    // Random traffic in four phases of idling and stalling, each with its own period.
    task automatic test_random_traffic();
        int unsigned phase_idle  [PHASES];
        int unsigned phase_stall [PHASES];
        logic [31:0] phase_period[PHASES];
        phase_idle   = '{0, 71, 0, 23};
        phase_stall  = '{0, 0, 71, 23};
        phase_period = '{32'd100, 32'($urandom_range(1, 600)), 32'hFFFF_FFFF, 32'd1};
        key_pool[0] = 64'd1;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            if (key_pool[i] == '0) begin
                key_pool[i] = 64'd2;
            end
        end
        wall_clock = $urandom_range(1000, 32'h7000_0000);
        for (int p = 0; p < PHASES; p++) begin
            write_repeat_period(phase_period[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            // The last phase starts the clock just below its 32-bit wrap.
            if (p == PHASES - 1) begin
                wall_clock = 32'hFFFF_F000;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Halfway through the sender holds off until the block has caught up.
                if (p == 1 && n == ITEMS_PER_PHASE / 2) begin
                    wait_until_drained();
                end
                send_item(random_item());
            end
        end
        wait_until_drained();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Each result transaction is compared with the oldest owed result.
    always @(posedge clk) begin : check_results
        ats_pkg::t_out want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %0d %0h %0b",
                         $time, res_ch.payload.status, res_ch.payload.fired_key,
                         res_ch.payload.last);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.payload.status !== want.status) begin
                    note_mismatch("status", 64'(want.status), 64'(res_ch.payload.status));
                end
                if (res_ch.payload.fired_key !== want.fired_key) begin
                    note_mismatch("fired_key", want.fired_key, res_ch.payload.fired_key);
                end
                if (res_ch.payload.last !== want.last) begin
                    note_mismatch("last", 64'(want.last), 64'(res_ch.payload.last));
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_commit_rules();
        test_check_rules();
        test_repeat_period_extremes();
        test_random_traffic();
        wait_until_drained();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Far beyond the slowest correct run, including every stall and every gap.
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
